[src/idpa_pkg.sv]
// Shared types, codes and arithmetic helpers for the int8 dot-product accumulator.
// No dependencies; every other file in src/ refers to this package by scoped names.
package idpa_pkg;

    // Channel and byte geometry
    localparam int CH_MAX    = 16;
    localparam int PAIRS     = CH_MAX / 2;
    localparam int LANES_DEF = 16;
    localparam int QUAD      = 4;

    // Input operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_ACC   = 1'b1;

    // Bias kinds
    localparam logic [1:0] BIAS_NONE = 2'd0;
    localparam logic [1:0] BIAS_S8   = 2'd1;
    localparam logic [1:0] BIAS_U8   = 2'd2;
    localparam logic [1:0] BIAS_S32  = 2'd3;

    // Output kinds (the unused code passes s32 through)
    localparam logic [1:0] OUT_S32 = 2'd0;
    localparam logic [1:0] OUT_S8  = 2'd1;
    localparam logic [1:0] OUT_U8  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_BIAS_KIND = 2'd0;
    localparam logic [1:0] CFG_OUT_KIND  = 2'd1;
    localparam logic [1:0] CFG_RELU_ON   = 2'd2;

    localparam logic signed [16:0] S16_MAX = 17'sd32767;
    localparam logic signed [16:0] S16_MIN = -17'sd32768;

    // Per-lane stage controls driven from the top level
    typedef struct packed {
        logic load;    // capture products and bias of an accepted beat
        logic acc_en;  // apply the captured beat to the accumulator
        logic start;   // captured beat is a start (bias load)
    } idpa_lane_ctrl_t;

    // Saturate a 17-bit pair sum to signed 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v > S16_MAX) begin
            r = 16'sh7FFF;
        end else if (v < S16_MIN) begin
            r = -16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // ReLU and narrowing of one accumulator
    function automatic logic [31:0] finish(input logic [31:0] acc,
                                           input logic [1:0]  kind,
                                           input logic        relu);
        logic signed [31:0] v;
        v = $signed(acc);
        if ((relu || (kind == OUT_U8)) && (v < 32'sd0)) begin
            v = 32'sd0;
        end
        if (kind == OUT_S8) begin
            if (v > 32'sd127) begin
                v = 32'sd127;
            end else if (v < -32'sd128) begin
                v = -32'sd128;
            end
        end else if (kind == OUT_U8) begin
            if (v > 32'sd255) begin
                v = 32'sd255;
            end
        end
        return $unsigned(v);
    endfunction

endpackage

[src/idpa_lane.sv]
// One channel lane: registered u8 x s8 products, then the saturating pair sums
// feeding the wrapping s32 accumulator. Depends on idpa_pkg.
module idpa_lane (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  idpa_pkg::idpa_lane_ctrl_t ctrl,
    input  logic [1:0]                bias_kind,
    input  logic [31:0]               act_quad,
    input  logic [31:0]               lane_word,
    output logic [31:0]               acc
);

    logic signed [16:0] prod_full [idpa_pkg::QUAD];
    logic signed [15:0] prod_reg  [idpa_pkg::QUAD];
    logic [31:0]        bias_next;
    logic [31:0]        bias_reg;
    logic signed [15:0] t0;
    logic signed [15:0] t1;
    logic signed [16:0] dot_sum;
    logic [31:0]        acc_reg;
    logic [31:0]        acc_next;

    // Multiply each activation byte by its weight byte
    always_comb begin
        for (int b = 0; b < idpa_pkg::QUAD; b++) begin
            prod_full[b] = $signed({1'b0, act_quad[8*b +: 8]}) * $signed(lane_word[8*b +: 8]);
        end
    end

    // Pick the bias from the raw word
    always_comb begin
        case (bias_kind)
            idpa_pkg::BIAS_S8:  bias_next = {{24{lane_word[7]}}, lane_word[7:0]};
            idpa_pkg::BIAS_U8:  bias_next = {24'd0, lane_word[7:0]};
            idpa_pkg::BIAS_S32: bias_next = lane_word;
            default:            bias_next = 32'd0;
        endcase
    end

    // Hold products and bias of the captured beat
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            for (int b = 0; b < idpa_pkg::QUAD; b++) begin
                prod_reg[b] <= prod_full[b][15:0];
            end
            bias_reg <= bias_next;
        end
    end

    // Saturate each pair, then combine
    always_comb begin
        t0 = idpa_pkg::sat16({prod_reg[0][15], prod_reg[0]} + {prod_reg[1][15], prod_reg[1]});
        t1 = idpa_pkg::sat16({prod_reg[2][15], prod_reg[2]} + {prod_reg[3][15], prod_reg[3]});
        dot_sum = {t0[15], t0} + {t1[15], t1};
        acc_next = ctrl.start ? bias_reg : acc_reg + {{15{dot_sum[16]}}, dot_sum};
    end

    // Advance the accumulator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= 32'd0;
        end else if (ctrl.acc_en) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

[src/idpa_merge.sv]
// Merge stage: ReLU and narrowing of every lane accumulator into the result register.
// Depends on idpa_pkg; channels at or above LANES read as zero.
module idpa_merge #(
    parameter int LANES = idpa_pkg::LANES_DEF
) (
    input  logic        aclk,
    input  logic        load,
    input  logic [1:0]  out_kind,
    input  logic        relu_on,
    input  logic [31:0] acc [LANES],
    output logic [31:0] res_word [idpa_pkg::CH_MAX]
);

    for (genvar ch = 0; ch < idpa_pkg::CH_MAX; ch++) begin : g_ch
        if (ch < LANES) begin : g_used
            logic [31:0] res_reg;

            // Capture the finished value of this channel
            always_ff @(posedge aclk) begin
                if (load) begin
                    res_reg <= idpa_pkg::finish(acc[ch], out_kind, relu_on);
                end
            end

            assign res_word[ch] = res_reg;
        end else begin : g_unused
            assign res_word[ch] = 32'd0;
        end
    end

endmodule

[src/int8_dot_product_accumulate_16lane.sv]
// 16-channel u8 x s8 dot-product accumulator with s32 accumulation and bias/ReLU/narrowing.
// Throughput: one beat per cycle while s_ready is high; each lane does one quad multiply-add per beat.
// A last accumulate beat reaches the output through the product register, the accumulator
// and the result register; back-pressure from m_ready can hold it at each register.
// Reset (synchronous, active low): accumulators and config clear to zero, pipeline empties.
// Depends on idpa_pkg, idpa_lane and idpa_merge.
module int8_dot_product_accumulate_16lane #(
    parameter int LANES = idpa_pkg::LANES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_index,
    input  logic [1:0]  cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [31:0] s_act_quad,
    input  logic [63:0] s_lane_pair_0,
    input  logic [63:0] s_lane_pair_1,
    input  logic [63:0] s_lane_pair_2,
    input  logic [63:0] s_lane_pair_3,
    input  logic [63:0] s_lane_pair_4,
    input  logic [63:0] s_lane_pair_5,
    input  logic [63:0] s_lane_pair_6,
    input  logic [63:0] s_lane_pair_7,
    input  logic        s_last,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_res_pair_0,
    output logic [63:0] m_res_pair_1,
    output logic [63:0] m_res_pair_2,
    output logic [63:0] m_res_pair_3,
    output logic [63:0] m_res_pair_4,
    output logic [63:0] m_res_pair_5,
    output logic [63:0] m_res_pair_6,
    output logic [63:0] m_res_pair_7
);

    logic [1:0]  bias_kind_reg;
    logic [1:0]  out_kind_reg;
    logic        relu_on_reg;

    logic        p1_valid_reg;
    logic        p1_valid_next;
    logic        p1_start_reg;
    logic        p1_last_reg;
    logic        fin_valid_reg;
    logic        fin_valid_next;
    logic        m_valid_reg;
    logic        m_valid_next;

    logic        out_free;
    logic        fin_ready;
    logic        acc_en;
    logic        s_accept;
    logic        fin_load;

    idpa_pkg::idpa_lane_ctrl_t lane_ctrl;

    logic [63:0] pair_in  [idpa_pkg::PAIRS];
    logic [31:0] lane_acc [LANES];
    logic [31:0] res_word [idpa_pkg::CH_MAX];

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_kind_reg <= idpa_pkg::BIAS_NONE;
            out_kind_reg  <= idpa_pkg::OUT_S32;
            relu_on_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                idpa_pkg::CFG_BIAS_KIND: bias_kind_reg <= cfg_wr_data;
                idpa_pkg::CFG_OUT_KIND:  out_kind_reg  <= cfg_wr_data;
                idpa_pkg::CFG_RELU_ON:   relu_on_reg   <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Pipeline flow: product stage -> accumulator -> result register
    always_comb begin
        out_free       = !m_valid_reg || m_ready;
        fin_ready      = !fin_valid_reg || out_free;
        acc_en         = p1_valid_reg && fin_ready;
        s_ready        = !p1_valid_reg || fin_ready;
        s_accept       = s_valid && s_ready;
        fin_load       = fin_valid_reg && out_free;
        p1_valid_next  = s_ready ? s_valid : p1_valid_reg;
        fin_valid_next = fin_ready ? (acc_en && (p1_start_reg == idpa_pkg::OP_ACC) && p1_last_reg)
                                   : fin_valid_reg;
        m_valid_next   = out_free ? fin_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            p1_valid_reg  <= p1_valid_next;
            fin_valid_reg <= fin_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Hold the op and last flag of the captured beat
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_start_reg <= (s_op == idpa_pkg::OP_START) ? idpa_pkg::OP_START : idpa_pkg::OP_ACC;
            p1_last_reg  <= s_last;
        end
    end

    always_comb begin
        lane_ctrl.load   = s_accept;
        lane_ctrl.acc_en = acc_en;
        lane_ctrl.start  = (p1_start_reg == idpa_pkg::OP_START);
    end

    assign pair_in[0] = s_lane_pair_0;
    assign pair_in[1] = s_lane_pair_1;
    assign pair_in[2] = s_lane_pair_2;
    assign pair_in[3] = s_lane_pair_3;
    assign pair_in[4] = s_lane_pair_4;
    assign pair_in[5] = s_lane_pair_5;
    assign pair_in[6] = s_lane_pair_6;
    assign pair_in[7] = s_lane_pair_7;

    // Lanes: channel 2i in the low half of pair i, channel 2i+1 in the high half
    for (genvar ch = 0; ch < LANES; ch++) begin : g_lane
        localparam int PI = ch / 2;
        logic [31:0] word;

        assign word = (ch % 2 == 1) ? pair_in[PI][63:32] : pair_in[PI][31:0];

        idpa_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (lane_ctrl),
            .bias_kind (bias_kind_reg),
            .act_quad  (s_act_quad),
            .lane_word (word),
            .acc       (lane_acc[ch])
        );
    end

    idpa_merge #(
        .LANES (LANES)
    ) u_merge (
        .aclk     (aclk),
        .load     (fin_load),
        .out_kind (out_kind_reg),
        .relu_on  (relu_on_reg),
        .acc      (lane_acc),
        .res_word (res_word)
    );

    assign m_valid      = m_valid_reg;
    assign m_res_pair_0 = {res_word[1],  res_word[0]};
    assign m_res_pair_1 = {res_word[3],  res_word[2]};
    assign m_res_pair_2 = {res_word[5],  res_word[4]};
    assign m_res_pair_3 = {res_word[7],  res_word[6]};
    assign m_res_pair_4 = {res_word[9],  res_word[8]};
    assign m_res_pair_5 = {res_word[11], res_word[10]};
    assign m_res_pair_6 = {res_word[13], res_word[12]};
    assign m_res_pair_7 = {res_word[15], res_word[14]};

    // A pending finish always reaches the output register
    a_fin_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_valid_reg |=> m_valid_reg)
        else $error("pending finish did not reach the output register");

    // A last accumulate applied to the lanes raises a finish
    a_last_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_en && !lane_ctrl.start && p1_last_reg) |=> fin_valid_reg)
        else $error("last accumulate beat produced no finish");

    // Input stalls only with every stage full
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (p1_valid_reg && fin_valid_reg && m_valid_reg))
        else $error("input stalled with room in the pipeline");

endmodule

[tb/tb_int8_dot_product_accumulate_16lane.sv]
// Self-checking testbench for the 16-channel u8 x s8 dot-product accumulator.
// Needs idpa_pkg and int8_dot_product_accumulate_16lane; drives directed rows, then random
// reductions under random sender gaps and receiver stalls, against a local predictor.
`timescale 1ns / 1ps

module tb_int8_dot_product_accumulate_16lane;

    localparam int CLK_NS          = 12;
    localparam int RESET_CYCLES    = 12;
    localparam int CHANNELS        = idpa_pkg::LANES_DEF;
    localparam int PIPE_SLACK      = 8;       // cycles to let a non-result beat retire
    localparam int HOLD_CYCLES     = 150;     // long receiver back-off
    localparam int HOLD_PHASE      = 3;
    localparam int PHASES          = 8;
    localparam int BEATS_PER_PHASE = 50;
    localparam int TIMEOUT_CYCLES  = 200000;
    localparam int DRAIN_LIMIT     = 20000;

    // Unused codes that the block must still tolerate
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam logic [1:0] OUT_UNUSED = 2'd3;

    typedef logic [idpa_pkg::CH_MAX*32-1:0] pixel_t;   // channel c in bits 32c+31..32c

    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  reg_idx;
        logic [1:0]  reg_val;
        logic        op;
        logic [31:0] act;
        pixel_t      lanes;
        logic        last;
        logic        typed;
        pixel_t      want;
    } step_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_wr_index;
    logic [1:0]  cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_op;
    logic [31:0] s_act_quad;
    logic [63:0] s_lane_pair_0, s_lane_pair_1, s_lane_pair_2, s_lane_pair_3;
    logic [63:0] s_lane_pair_4, s_lane_pair_5, s_lane_pair_6, s_lane_pair_7;
    logic        s_last;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_res_pair_0, m_res_pair_1, m_res_pair_2, m_res_pair_3;
    logic [63:0] m_res_pair_4, m_res_pair_5, m_res_pair_6, m_res_pair_7;

    // Predictor state
    logic [31:0] acc_bank [idpa_pkg::CH_MAX];
    logic [1:0]  bias_sel;
    logic [1:0]  out_sel;
    logic        relu_sel;

    pixel_t pixel_q [$];
    step_t  directed_rows [$];

    int errors;
    int pixels_seen;
    int beats_sent;
    int reg_writes;
    int burst_left;
    int stall_cycles;
    bit hold_req;
    bit hold_go;

    pixel_t mon_got;
    pixel_t mon_want;
    int     mon_ch;

    int8_dot_product_accumulate_16lane #(
        .LANES(CHANNELS)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_act_quad    (s_act_quad),
        .s_lane_pair_0 (s_lane_pair_0),
        .s_lane_pair_1 (s_lane_pair_1),
        .s_lane_pair_2 (s_lane_pair_2),
        .s_lane_pair_3 (s_lane_pair_3),
        .s_lane_pair_4 (s_lane_pair_4),
        .s_lane_pair_5 (s_lane_pair_5),
        .s_lane_pair_6 (s_lane_pair_6),
        .s_lane_pair_7 (s_lane_pair_7),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_res_pair_0  (m_res_pair_0),
        .m_res_pair_1  (m_res_pair_1),
        .m_res_pair_2  (m_res_pair_2),
        .m_res_pair_3  (m_res_pair_3),
        .m_res_pair_4  (m_res_pair_4),
        .m_res_pair_5  (m_res_pair_5),
        .m_res_pair_6  (m_res_pair_6),
        .m_res_pair_7  (m_res_pair_7)
    );

    // Print one mismatch line and count it
    task automatic report(input string msg);
        errors++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Predictor arithmetic
    function automatic int mul_byte(input logic [31:0] act, input logic [31:0] w, input int b);
        return int'(act[8*b +: 8]) * int'($signed(w[8*b +: 8]));
    endfunction

    function automatic int sat_s16(input int v);
        if (v > 32767) begin
            return 32767;
        end
        if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    function automatic logic [31:0] pred_finish(input logic [31:0] acc);
        int v;
        v = int'($signed(acc));
        if ((relu_sel || (out_sel == idpa_pkg::OUT_U8)) && (v < 0)) begin
            v = 0;
        end
        if (out_sel == idpa_pkg::OUT_S8) begin
            if (v > 127) begin
                v = 127;
            end else if (v < -128) begin
                v = -128;
            end
        end else if (out_sel == idpa_pkg::OUT_U8) begin
            if (v > 255) begin
                v = 255;
            end
        end
        return 32'(v);
    endfunction

    task automatic pred_reset();
        for (int ch = 0; ch < idpa_pkg::CH_MAX; ch++) begin
            acc_bank[ch] = 32'd0;
        end
        bias_sel = idpa_pkg::BIAS_NONE;
        out_sel  = idpa_pkg::OUT_S32;
        relu_sel = 1'b0;
    endtask

    task automatic pred_config(input logic [1:0] idx, input logic [1:0] val);
        case (idx)
            idpa_pkg::CFG_BIAS_KIND: bias_sel = val;
            idpa_pkg::CFG_OUT_KIND:  out_sel  = val;
            idpa_pkg::CFG_RELU_ON:   relu_sel = val[0];
            default: ;
        endcase
    endtask

    task automatic pred_step(input step_t row, output bit has_res, output pixel_t res);
        logic [31:0] w;
        int t0;
        int t1;
        has_res = 1'b0;
        res     = '0;
        if (row.op == idpa_pkg::OP_START) begin
            // Load the bias; last is ignored on a start beat
            for (int ch = 0; ch < CHANNELS; ch++) begin
                w = row.lanes[32*ch +: 32];
                case (bias_sel)
                    idpa_pkg::BIAS_S8:  acc_bank[ch] = {{24{w[7]}}, w[7:0]};
                    idpa_pkg::BIAS_U8:  acc_bank[ch] = {24'd0, w[7:0]};
                    idpa_pkg::BIAS_S32: acc_bank[ch] = w;
                    default:            acc_bank[ch] = 32'd0;
                endcase
            end
        end else begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                w  = row.lanes[32*ch +: 32];
                t0 = sat_s16(mul_byte(row.act, w, 0) + mul_byte(row.act, w, 1));
                t1 = sat_s16(mul_byte(row.act, w, 2) + mul_byte(row.act, w, 3));
                acc_bank[ch] = acc_bank[ch] + 32'(t0 + t1);
            end
            if (row.last) begin
                has_res = 1'b1;
                for (int ch = 0; ch < CHANNELS; ch++) begin
                    res[32*ch +: 32] = pred_finish(acc_bank[ch]);
                end
            end
        end
    endtask

    // Row builders
    function automatic step_t cfg_row(input logic [1:0] idx, input logic [1:0] val);
        step_t r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic step_t beat_row(input logic op, input logic [31:0] act,
                                       input pixel_t lanes, input logic last);
        step_t r;
        r = '0;
        r.op    = op;
        r.act   = act;
        r.lanes = lanes;
        r.last  = last;
        return r;
    endfunction

    function automatic step_t typed_row(input logic op, input logic [31:0] act,
                                        input pixel_t lanes, input logic last,
                                        input pixel_t want);
        step_t r;
        r = beat_row(op, act, lanes, last);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic step_t rand_row(input int start_pct, input int last_pct);
        step_t r;
        int style;
        logic [31:0] w;
        r = '0;
        style = $urandom_range(0, 3);
        r.op  = ($urandom_range(0, 99) < start_pct) ? idpa_pkg::OP_START : idpa_pkg::OP_ACC;
        r.act = (style == 0) ? 32'hFFFFFFFF : $urandom();
        for (int ch = 0; ch < idpa_pkg::CH_MAX; ch++) begin
            if (style == 0) begin
                w = $urandom_range(0, 1) ? 32'h7F7F7F7F : 32'h80808080;
            end else begin
                w = $urandom();
            end
            r.lanes[32*ch +: 32] = w;
        end
        r.last = ($urandom_range(0, 99) < last_pct);
        return r;
    endfunction

    // Offer one beat at the falling edge and hold it until accepted
    task automatic send_beat(input step_t row);
        bit     has_res;
        pixel_t res;
        @(negedge aclk);
        s_valid       = 1'b1;
        s_op          = row.op;
        s_act_quad    = row.act;
        s_lane_pair_0 = row.lanes[63:0];
        s_lane_pair_1 = row.lanes[127:64];
        s_lane_pair_2 = row.lanes[191:128];
        s_lane_pair_3 = row.lanes[255:192];
        s_lane_pair_4 = row.lanes[319:256];
        s_lane_pair_5 = row.lanes[383:320];
        s_lane_pair_6 = row.lanes[447:384];
        s_lane_pair_7 = row.lanes[511:448];
        s_last        = row.last;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        beats_sent++;
        pred_step(row, has_res, res);
        if (has_res) begin
            if (row.typed) begin
                if (res !== row.want) begin
                    report($sformatf("beat %0d: predictor disagrees with typed value", beats_sent));
                end
                pixel_q.push_back(row.want);
            end else begin
                pixel_q.push_back(res);
            end
        end
    endtask

    // Drop valid for a number of cycles
    task automatic idle_gap(input int cycles);
        @(negedge aclk);
        s_valid = 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    // Drop valid and wait until every expected result has come out
    task automatic wait_idle();
        int n;
        n = 0;
        @(negedge aclk);
        s_valid = 1'b0;
        while ((pixel_q.size() != 0) && (n < DRAIN_LIMIT)) begin
            @(negedge aclk);
            n++;
        end
        if (pixel_q.size() != 0) begin
            report($sformatf("%0d results never came out", pixel_q.size()));
            pixel_q.delete();
        end
        repeat (PIPE_SLACK) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [1:0] val);
        @(negedge aclk);
        cfg_wr_en    = 1'b1;
        cfg_wr_index = idx;
        cfg_wr_data  = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        reg_writes++;
        pred_config(idx, val);
    endtask

    function automatic int first_diff(input pixel_t a, input pixel_t b);
        int idx;
        idx = -1;
        for (int ch = idpa_pkg::CH_MAX - 1; ch >= 0; ch--) begin
            if (a[32*ch +: 32] !== b[32*ch +: 32]) begin
                idx = ch;
            end
        end
        return idx;
    endfunction

    // Clock
    initial begin : clk_proc
        aclk = 1'b0;
        forever #(CLK_NS / 2) aclk = ~aclk;
    end

    // Receiver: stall on its own pattern, and back off fully while a hold is on
    initial begin : rx_proc
        int cyc;
        cyc = 0;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            cyc++;
            m_ready = !hold_req && ((cyc % 5) != 2) && ($urandom_range(0, 7) != 0);
        end
    end

    // Long receiver back-off, counted here
    initial begin : hold_proc
        hold_req = 1'b0;
        wait (hold_go);
        @(negedge aclk);
        hold_req = 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        hold_req = 1'b0;
    end

    // Count input stalls and check every result beat against the expected queue
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && !s_ready) begin
                stall_cycles++;
            end
            if (m_valid && m_ready) begin
                mon_got = {m_res_pair_7, m_res_pair_6, m_res_pair_5, m_res_pair_4,
                           m_res_pair_3, m_res_pair_2, m_res_pair_1, m_res_pair_0};
                if (pixel_q.size() == 0) begin
                    report("result beat with none expected");
                end else begin
                    mon_want = pixel_q.pop_front();
                    pixels_seen++;
                    if (mon_got !== mon_want) begin
                        mon_ch = first_diff(mon_got, mon_want);
                        report($sformatf("result %0d channel %0d: got %08h want %08h",
                                         pixels_seen, mon_ch, mon_got[32*mon_ch +: 32],
                                         mon_want[32*mon_ch +: 32]));
                    end
                end
            end
        end
    end

    // Run limit
    initial begin : limit_proc
        #(CLK_NS * TIMEOUT_CYCLES);
        $display("run limit reached with %0d results outstanding", pixel_q.size());
        $display("tb_int8_dot_product_accumulate_16lane NOT OK");
        $finish;
    end

    // Stimulus
    initial begin : main_proc
        int max_gap;
        int start_pct;
        int last_pct;
        int nwr;
        errors       = 0;
        pixels_seen  = 0;
        beats_sent   = 0;
        reg_writes   = 0;
        burst_left   = 0;
        stall_cycles = 0;
        hold_go      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = 2'd0;
        cfg_wr_data  = 2'd0;
        s_valid      = 1'b0;
        s_op         = idpa_pkg::OP_START;
        s_act_quad   = 32'd0;
        s_lane_pair_0 = 64'd0;
        s_lane_pair_1 = 64'd0;
        s_lane_pair_2 = 64'd0;
        s_lane_pair_3 = 64'd0;
        s_lane_pair_4 = 64'd0;
        s_lane_pair_5 = 64'd0;
        s_lane_pair_6 = 64'd0;
        s_lane_pair_7 = 64'd0;
        s_last       = 1'b0;
        pred_reset();

        // Directed rows: extremes, saturation and every narrowing mode
        directed_rows.push_back(typed_row(idpa_pkg::OP_ACC, 32'h0, '0, 1'b1, '0));
        directed_rows.push_back(cfg_row(idpa_pkg::CFG_BIAS_KIND, idpa_pkg::BIAS_S32));
        directed_rows.push_back(beat_row(idpa_pkg::OP_START, 32'h0,
                                         {idpa_pkg::CH_MAX{32'h7FFFFFFF}}, 1'b0));
        directed_rows.push_back(typed_row(idpa_pkg::OP_ACC, 32'hFFFFFFFF,
                                          {idpa_pkg::CH_MAX{32'h7F7F7F7F}}, 1'b1,
                                          {idpa_pkg::CH_MAX{32'h8000FFFD}}));
        directed_rows.push_back(beat_row(idpa_pkg::OP_START, 32'h0, '0, 1'b0));
        directed_rows.push_back(typed_row(idpa_pkg::OP_ACC, 32'hFFFFFFFF,
                                          {idpa_pkg::CH_MAX{32'h80808080}}, 1'b1,
                                          {idpa_pkg::CH_MAX{32'hFFFF0000}}));
        directed_rows.push_back(cfg_row(idpa_pkg::CFG_OUT_KIND, idpa_pkg::OUT_S8));
        directed_rows.push_back(beat_row(idpa_pkg::OP_START, 32'h0, '0, 1'b0));
        directed_rows.push_back(typed_row(idpa_pkg::OP_ACC, 32'hFFFFFFFF,
                                          {idpa_pkg::CH_MAX{32'h80808080}}, 1'b1,
                                          {idpa_pkg::CH_MAX{32'hFFFFFF80}}));
        directed_rows.push_back(cfg_row(idpa_pkg::CFG_RELU_ON, 2'd1));
        directed_rows.push_back(beat_row(idpa_pkg::OP_START, 32'h0, '0, 1'b0));
        directed_rows.push_back(typed_row(idpa_pkg::OP_ACC, 32'hFFFFFFFF,
                                          {idpa_pkg::CH_MAX{32'h80808080}}, 1'b1, '0));
        directed_rows.push_back(cfg_row(idpa_pkg::CFG_RELU_ON, 2'd0));
        directed_rows.push_back(cfg_row(idpa_pkg::CFG_OUT_KIND, idpa_pkg::OUT_U8));
        directed_rows.push_back(beat_row(idpa_pkg::OP_START, 32'h0, '0, 1'b0));
        directed_rows.push_back(typed_row(idpa_pkg::OP_ACC, 32'hFFFFFFFF,
                                          {idpa_pkg::CH_MAX{32'h7F7F7F7F}}, 1'b1,
                                          {idpa_pkg::CH_MAX{32'h000000FF}}));
        directed_rows.push_back(beat_row(idpa_pkg::OP_START, 32'h0, '0, 1'b0));
        directed_rows.push_back(typed_row(idpa_pkg::OP_ACC, 32'hFFFFFFFF,
                                          {idpa_pkg::CH_MAX{32'h80808080}}, 1'b1, '0));
        directed_rows.push_back(cfg_row(idpa_pkg::CFG_BIAS_KIND, idpa_pkg::BIAS_U8));
        directed_rows.push_back(cfg_row(idpa_pkg::CFG_OUT_KIND, OUT_UNUSED));
        directed_rows.push_back(beat_row(idpa_pkg::OP_START, 32'h0,
                                         {idpa_pkg::CH_MAX{32'hFFFFFF90}}, 1'b0));
        directed_rows.push_back(typed_row(idpa_pkg::OP_ACC, 32'h0, '0, 1'b1,
                                          {idpa_pkg::CH_MAX{32'h00000090}}));
        directed_rows.push_back(rand_row(0, 100));
        directed_rows.push_back(cfg_row(idpa_pkg::CFG_BIAS_KIND, idpa_pkg::BIAS_S8));
        directed_rows.push_back(cfg_row(CFG_UNUSED, 2'd2));
        directed_rows.push_back(beat_row(idpa_pkg::OP_START, 32'h0,
                                         {idpa_pkg::CH_MAX{32'h12345680}}, 1'b1));
        directed_rows.push_back(typed_row(idpa_pkg::OP_ACC, 32'h0, '0, 1'b1,
                                          {idpa_pkg::CH_MAX{32'hFFFFFF80}}));
        directed_rows.push_back(rand_row(0, 0));
        directed_rows.push_back(rand_row(0, 100));

        // Reset
        aresetn = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Walk the directed table
        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_cfg) begin
                wait_idle();
                cfg_write(directed_rows[k].reg_idx, directed_rows[k].reg_val);
            end else begin
                send_beat(directed_rows[k]);
            end
        end

        // Random reductions, new settings per phase
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            nwr = $urandom_range(1, 3);
            for (int i = 0; i < nwr; i++) begin
                cfg_write(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
            end
            if (phase == HOLD_PHASE) begin
                max_gap   = 1;
                start_pct = 5;
                last_pct  = 60;
                hold_go   = 1'b1;
            end else begin
                max_gap   = 4;
                start_pct = 15;
                last_pct  = 25;
            end
            burst_left = 0;
            for (int i = 0; i < BEATS_PER_PHASE; i++) begin
                if (burst_left == 0) begin
                    idle_gap($urandom_range(1, max_gap));
                    burst_left = $urandom_range(1, 8);
                end
                send_beat(rand_row(start_pct, last_pct));
                burst_left--;
            end
        end

        wait_idle();

        $display("Covered %0d beats, %0d register writes, %0d results checked, %0d stalled cycles.",
                 beats_sent, reg_writes, pixels_seen, stall_cycles);
        $display("Included saturation extremes, all bias and output modes, and a long output hold.");
        if (errors == 0) begin
            $display("tb_int8_dot_product_accumulate_16lane OK");
        end else begin
            $display("tb_int8_dot_product_accumulate_16lane NOT OK");
        end
        $finish;
    end

endmodule

[files.f]
src/idpa_pkg.sv
src/idpa_lane.sv
src/idpa_merge.sv
src/int8_dot_product_accumulate_16lane.sv
tb/tb_int8_dot_product_accumulate_16lane.sv
